@@ hw/rtl/broadcast_message_queue_top_defines.svh @@
// Assertion macros for the broadcast message queue.
`ifndef BROADCAST_MESSAGE_QUEUE_TOP_DEFINES_SVH
`define BROADCAST_MESSAGE_QUEUE_TOP_DEFINES_SVH
`ifndef SYNTH
`define BMQ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BMQ_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BMQ_ASSERT(label, clk, rst, prop, msg)
`define BMQ_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ hw/rtl/bmq_pkg.sv @@
// Types and codes shared by the broadcast message queue modules.
package bmq_pkg;
   typedef enum logic [2:0] {
      KIND_SUBSCRIBE   = 3'd0,
      KIND_UNSUBSCRIBE = 3'd1,
      KIND_ADD         = 3'd2,
      KIND_GET         = 3'd3,
      KIND_COUNT       = 3'd4,
      KIND_REMOVE      = 3'd5,
      KIND_RESIZE      = 3'd6,
      KIND_NONE        = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_FULL      = 3'd1,
      ST_NOT_SUB   = 3'd2,
      ST_NONE      = 3'd3,
      ST_NOT_FOUND = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      EX_IDLE, EX_SCAN, EX_SHIFT, EX_DONE
   } exec_state_type;

   // one decoded request handed from front to back
   typedef struct packed {
      kind_type    kind;
      logic [15:0] id;
      logic [31:0] handle;
      logic [4:0]  new_capacity;
   } request_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] handle_out;
      logic [4:0]  available;
      logic [4:0]  dropped;
   } response_type;
endpackage

@@ hw/rtl/bmq_front.sv @@
// Input side: accepts request beats into a two-entry queue.
module bmq_front
   import bmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,
   output logic        q_valid,
   input  logic        q_take,
   output request_type q_head
);
   request_type entry_ff [2];
   logic [1:0]  count_ff, count_in;
   logic        push, pop;
   request_type incoming;

   assign incoming.kind         = kind_type'(req_tdata[2:0]);
   assign incoming.id           = req_tdata[18:3];
   assign incoming.handle       = req_tdata[50:19];
   assign incoming.new_capacity = req_tdata[55:51];

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign pop        = q_take && q_valid;
   assign q_valid    = (count_ff != 2'd0);
   assign q_head     = entry_ff[0];

   // occupancy
   always_comb begin
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   // entry 0 is the head
   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff[0] <= (count_ff == 2'd2) ? entry_ff[1] : incoming;
         if (push) entry_ff[1] <= incoming;
      end else if (push) begin
         if (count_ff == 2'd0) entry_ff[0] <= incoming;
         else entry_ff[1] <= incoming;
      end
   end
endmodule

@@ hw/rtl/bmq_back.sv @@
// Execution side: subscriber table and message store, one entry a cycle.
module bmq_back
   import bmq_pkg::*;
#(
   parameter int MESSAGE_DEPTH    = 16,
   parameter int SUBSCRIBER_SLOTS = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         q_valid,
   output logic         q_take,
   input  request_type  q_head,
   output logic         rsp_valid,
   input  logic         rsp_take,
   output response_type rsp_data
);
   localparam int IW = (MESSAGE_DEPTH > 1) ? $clog2(MESSAGE_DEPTH) : 1;
   localparam int CW = $clog2(MESSAGE_DEPTH + 1);
   localparam int SW = (SUBSCRIBER_SLOTS > 1) ? $clog2(SUBSCRIBER_SLOTS) : 1;

   logic [15:0]                 sub_id_ff    [SUBSCRIBER_SLOTS];
   logic [SUBSCRIBER_SLOTS-1:0] sub_valid_ff;
   logic [31:0]                 msg_ff       [MESSAGE_DEPTH];
   logic [SUBSCRIBER_SLOTS-1:0] map_ff       [MESSAGE_DEPTH];
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               cap_ff;

   exec_state_type state_ff, state_in;
   request_type    req_ff;
   logic [CW-1:0]  idx_ff, idx_in;      // scan / shift position
   logic [CW-1:0]  src_ff, src_in;      // shift source offset
   logic [4:0]     tally_ff, tally_in;
   response_type   out_ff, out_in;
   logic           out_valid_ff, out_valid_in;

   // slot lookup over the small subscriber table
   logic [SUBSCRIBER_SLOTS-1:0] hit_vec;
   logic                        hit, has_free;
   logic [SW-1:0]               hit_slot, free_slot;
   always_comb begin
      hit = 1'b0; hit_slot = '0; has_free = 1'b0; free_slot = '0;
      for (int s = SUBSCRIBER_SLOTS - 1; s >= 0; s--) begin
         hit_vec[s] = sub_valid_ff[s] && (sub_id_ff[s] == req_ff.id) && (req_ff.id != 16'd0);
         if (hit_vec[s]) begin hit = 1'b1; hit_slot = SW'(s); end
         if (!sub_valid_ff[s]) begin has_free = 1'b1; free_slot = SW'(s); end
      end
   end

   logic [SUBSCRIBER_SLOTS-1:0] hit_mask;
   assign hit_mask = hit_vec;

   logic [IW-1:0] idx_w, nxt_w;
   logic [CW-1:0] idx_p1;
   logic [CW-1:0] newcap;
   logic [CW-1:0] drop_n;
   assign idx_w  = idx_ff[IW-1:0];
   assign idx_p1 = idx_ff + CW'(1);
   assign newcap = ({{(CW > 5 ? CW - 5 : 0){1'b0}}, q_head.new_capacity} > CW'(MESSAGE_DEPTH))
                   ? CW'(MESSAGE_DEPTH) : CW'(q_head.new_capacity);
   assign drop_n = count_ff - newcap;

   logic [CW-1:0] shift_src;
   assign shift_src = idx_ff + src_ff;
   assign nxt_w     = shift_src[IW-1:0];

   logic in_range, cur_hit;
   logic [SUBSCRIBER_SLOTS-1:0] cur_map_clr;
   assign in_range    = (idx_ff < count_ff);
   assign cur_hit     = |(map_ff[idx_w] & hit_mask);
   assign cur_map_clr = map_ff[idx_w] & ~hit_mask;

   // control decisions
   logic do_sub, do_unsub, do_add, do_map_clr, do_dec, do_resize;
   always_comb begin
      state_in = state_ff; idx_in = idx_ff; src_in = src_ff; tally_in = tally_ff;
      out_in = out_ff; out_valid_in = out_valid_ff; q_take = 1'b0;
      do_sub = 1'b0; do_unsub = 1'b0; do_add = 1'b0; do_map_clr = 1'b0;
      do_dec = 1'b0; do_resize = 1'b0;
      if (out_valid_ff && rsp_take) out_valid_in = 1'b0;
      case (state_ff)
         EX_IDLE: begin
            // the result register is reused, so wait until it has been taken
            if (q_valid && (!out_valid_ff || rsp_take)) begin
               q_take = 1'b1;
               idx_in = '0; src_in = CW'(1); tally_in = '0;
               out_in = '{status: ST_OK, handle_out: '0, available: '0, dropped: '0};
               state_in = EX_SCAN;
               if (q_head.kind == KIND_RESIZE) begin
                  do_resize = 1'b1;
                  if (count_ff > newcap) begin
                     src_in = drop_n;
                     out_in.dropped = (drop_n > CW'(31)) ? 5'd31 : 5'(drop_n);
                     state_in = EX_SHIFT;
                  end else begin
                     state_in = EX_DONE;
                  end
               end
            end
         end
         EX_SCAN: begin
            case (req_ff.kind)
               KIND_SUBSCRIBE: begin
                  if (req_ff.id == 16'd0 || hit) out_in.status = ST_NOT_SUB;
                  else if (!has_free) out_in.status = ST_FULL;
                  else do_sub = 1'b1;
                  state_in = EX_DONE;
               end
               KIND_ADD: begin
                  if (count_ff >= cap_ff || count_ff >= CW'(MESSAGE_DEPTH))
                     out_in.status = ST_FULL;
                  else do_add = 1'b1;
                  state_in = EX_DONE;
               end
               KIND_UNSUBSCRIBE: begin
                  if (!hit) begin
                     out_in.status = ST_NOT_SUB; state_in = EX_DONE;
                  end else if (!in_range) begin
                     do_unsub = 1'b1; state_in = EX_DONE;
                  end else if (cur_hit) begin
                     if (cur_map_clr == '0) begin
                        state_in = EX_SHIFT;
                     end else begin
                        do_map_clr = 1'b1; idx_in = idx_p1;
                     end
                  end else idx_in = idx_p1;
               end
               KIND_GET: begin
                  if (!hit || cap_ff == '0) begin
                     out_in.status = ST_NOT_SUB; state_in = EX_DONE;
                  end else if (!in_range) begin
                     out_in.status = ST_NONE; state_in = EX_DONE;
                  end else if (cur_hit) begin
                     out_in.handle_out = msg_ff[idx_w];
                     if (cur_map_clr == '0) begin
                        state_in = EX_SHIFT;
                     end else begin
                        do_map_clr = 1'b1; state_in = EX_DONE;
                     end
                  end else idx_in = idx_p1;
               end
               KIND_COUNT: begin
                  if (!hit || !in_range) begin
                     out_in.available = tally_ff; state_in = EX_DONE;
                  end else begin
                     // tally saturates at the field's top value
                     if (cur_hit && tally_ff != 5'd31) tally_in = tally_ff + 5'd1;
                     idx_in = idx_p1;
                  end
               end
               KIND_REMOVE: begin
                  if (req_ff.handle == 32'd0 || !in_range) begin
                     out_in.status = ST_NOT_FOUND; state_in = EX_DONE;
                  end else if (msg_ff[idx_w] == req_ff.handle) begin
                     state_in = EX_SHIFT;
                  end else idx_in = idx_p1;
               end
               default: state_in = EX_DONE;
            endcase
         end
         EX_SHIFT: begin
            // move one entry down by src_ff; finishes when source reaches the count
            if (shift_src < count_ff) begin
               idx_in = idx_p1;
            end else begin
               do_dec = 1'b1;
               if (req_ff.kind == KIND_UNSUBSCRIBE) begin
                  // entries behind the dropped one are still unscanned
                  idx_in = '0; state_in = EX_SCAN;
               end else state_in = EX_DONE;
            end
         end
         EX_DONE: begin
            if (!out_valid_ff || rsp_take) begin
               out_valid_in = 1'b1; state_in = EX_IDLE;
            end
         end
         default: state_in = EX_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= EX_IDLE; out_valid_ff <= 1'b0; sub_valid_ff <= '0;
         count_ff <= '0; cap_ff <= CW'(MESSAGE_DEPTH);
      end else begin
         state_ff <= state_in; out_valid_ff <= out_valid_in;
         if (do_sub) sub_valid_ff[free_slot] <= 1'b1;
         if (do_unsub) sub_valid_ff[hit_slot] <= 1'b0;
         if (do_add) count_ff <= count_ff + CW'(1);
         if (do_dec) count_ff <= count_ff - src_ff;
         if (do_resize) cap_ff <= newcap;
      end
   end

   // payload and store updates
   always_ff @(posedge clock) begin
      idx_ff <= idx_in; src_ff <= src_in; tally_ff <= tally_in; out_ff <= out_in;
      if (q_take) req_ff <= q_head;
      if (do_sub) sub_id_ff[free_slot] <= req_ff.id;
      if (do_add) begin
         msg_ff[count_ff[IW-1:0]] <= req_ff.handle;
         map_ff[count_ff[IW-1:0]] <= sub_valid_ff;
      end
      if (do_map_clr) map_ff[idx_w] <= cur_map_clr;
      if (state_ff == EX_SHIFT && shift_src < count_ff) begin
         msg_ff[idx_w] <= msg_ff[nxt_w];
         map_ff[idx_w] <= map_ff[nxt_w];
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
endmodule

@@ hw/rtl/broadcast_message_queue_top.sv @@
// Top level of the broadcast message queue.
// Each request beat gets exactly one response beat. The back end takes a
// beat from the two-entry front queue only once the previous response has
// left, then answers subscribe and add after one scan step and a resize that
// drops nothing directly from idle. Get, count and remove walk the message
// store one entry a cycle, and get, remove and a shrinking resize compact it
// by shifting entries down in the same pass. Unsubscribe restarts its walk
// after every message it drops. The front queue keeps taking new beats
// meanwhile until its two entries are full.
`include "broadcast_message_queue_top_defines.svh"
module broadcast_message_queue_top
   import bmq_pkg::*;
#(
   parameter int MESSAGE_DEPTH    = 16,
   parameter int SUBSCRIBER_SLOTS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // kind[2:0], subscriber_id, message_handle, new_capacity
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // status[2:0], message_handle_out, available, dropped
);
   logic         q_valid, q_take;
   request_type  q_head;
   response_type rsp_data;

   bmq_front u_front (
      .clock, .reset, .req_tvalid, .req_tready, .req_tdata,
      .q_valid, .q_take, .q_head
   );

   bmq_back #(.MESSAGE_DEPTH(MESSAGE_DEPTH), .SUBSCRIBER_SLOTS(SUBSCRIBER_SLOTS)) u_back (
      .clock, .reset, .q_valid, .q_take, .q_head,
      .rsp_valid(rsp_tvalid), .rsp_take(rsp_tready), .rsp_data
   );

   assign rsp_tdata = {3'd0, rsp_data.dropped, rsp_data.available,
                       rsp_data.handle_out, rsp_data.status};

   `BMQ_ASSERT(a_status_range, clock, reset, rsp_tvalid |-> rsp_tdata[2:0] <= ST_NOT_FOUND, "bad status")
   `BMQ_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "response dropped")
   `BMQ_ASSERT(a_get_zero, clock, reset, rsp_tvalid && rsp_tdata[2:0] != ST_OK |-> rsp_tdata[34:3] == 32'd0, "handle on failure")
endmodule

@@ verif/bmq_checker.sv @@
// Checker for the broadcast message queue: predicts each response and compares it.
module bmq_checker
   import bmq_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [55:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [47:0] rsp_tdata,
   output int          error_count,
   output int          pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 16;
   localparam int SLOTS = 8;

   // predictor state
   logic [15:0] sub_ids [SLOTS];
   logic [SLOTS-1:0] sub_live;
   logic [31:0] msg_handles [DEPTH];
   logic [SLOTS-1:0] msg_readers [DEPTH];
   int msg_total;
   int cap;

   response_type expected_rsps [$];

   assign pending_count = expected_rsps.size();

   function automatic int slot_of(logic [15:0] id);
      for (int s = 0; s < SLOTS; s++)
         if (sub_live[s] && sub_ids[s] == id) return s;
      return SLOTS;
   endfunction

   function automatic void drop_at(int pos);
      for (int i = pos; i + 1 < msg_total; i++) begin
         msg_handles[i] = msg_handles[i+1];
         msg_readers[i] = msg_readers[i+1];
      end
      msg_total--;
   endfunction

   // work out the response to one request beat and update the state
   function automatic response_type serve_request(request_type rq);
      response_type r;
      int s;
      int n;
      int diff;
      int ncap;
      int i;
      r = '0;
      r.status = ST_OK;
      s = (rq.id == 0) ? SLOTS : slot_of(rq.id);
      case (rq.kind)
         KIND_SUBSCRIBE: begin
            if (rq.id == 0 || s < SLOTS) r.status = ST_NOT_SUB;
            else begin
               s = SLOTS;
               for (int k = SLOTS - 1; k >= 0; k--) if (!sub_live[k]) s = k;
               if (s == SLOTS) r.status = ST_FULL;
               else begin
                  sub_ids[s] = rq.id;
                  sub_live[s] = 1'b1;
               end
            end
         end
         KIND_UNSUBSCRIBE: begin
            if (s == SLOTS) r.status = ST_NOT_SUB;
            else begin
               sub_live[s] = 1'b0;
               i = 0;
               while (i < msg_total) begin
                  if (msg_readers[i][s]) begin
                     msg_readers[i][s] = 1'b0;
                     if (msg_readers[i] == 0) begin
                        drop_at(i);
                        continue;
                     end
                  end
                  i++;
               end
            end
         end
         KIND_ADD: begin
            if (msg_total >= cap) r.status = ST_FULL;
            else begin
               msg_handles[msg_total] = rq.handle;
               msg_readers[msg_total] = sub_live;
               msg_total++;
            end
         end
         KIND_GET: begin
            if (s == SLOTS || cap == 0) r.status = ST_NOT_SUB;
            else begin
               r.status = ST_NONE;
               for (i = 0; i < msg_total; i++)
                  if (msg_readers[i][s]) begin
                     msg_readers[i][s] = 1'b0;
                     r.handle_out = msg_handles[i];
                     r.status = ST_OK;
                     if (msg_readers[i] == 0) drop_at(i);
                     break;
                  end
            end
         end
         KIND_COUNT: begin
            n = 0;
            if (s < SLOTS)
               for (i = 0; i < msg_total; i++) if (msg_readers[i][s]) n++;
            r.available = n[4:0];
         end
         KIND_REMOVE: begin
            r.status = ST_NOT_FOUND;
            if (rq.handle != 0)
               for (i = 0; i < msg_total; i++)
                  if (msg_handles[i] == rq.handle) begin
                     drop_at(i);
                     r.status = ST_OK;
                     break;
                  end
         end
         KIND_RESIZE: begin
            ncap = (rq.new_capacity > DEPTH) ? DEPTH : rq.new_capacity;
            if (msg_total > ncap) begin
               diff = msg_total - ncap;
               for (i = 0; i < ncap; i++) begin
                  msg_handles[i] = msg_handles[i+diff];
                  msg_readers[i] = msg_readers[i+diff];
               end
               msg_total = ncap;
               r.dropped = diff[4:0];
            end
            cap = ncap;
         end
         default: ;
      endcase
      return r;
   endfunction

   // watch both channels at the rising edge
   always @(posedge clock) begin
      response_type got;
      response_type want;
      request_type  rq_in;
      if (reset) begin
         sub_live = '0;
         msg_total = 0;
         cap = DEPTH;
         error_count = 0;
         expected_rsps.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            // unpack the beat, lowest field first
            got.status     = rsp_tdata[2:0];
            got.handle_out = rsp_tdata[34:3];
            got.available  = rsp_tdata[39:35];
            got.dropped    = rsp_tdata[44:40];
            if (expected_rsps.size() == 0) begin
               $display("%0t: response beat with nothing expected: %h", $time, got);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
                  error_count++;
               end
               if (got.handle_out !== want.handle_out) begin
                  $display("%0t: handle expected %h got %h", $time, want.handle_out,
                           got.handle_out);
                  error_count++;
               end
               if (got.available !== want.available) begin
                  $display("%0t: available expected %0d got %0d", $time, want.available,
                           got.available);
                  error_count++;
               end
               if (got.dropped !== want.dropped) begin
                  $display("%0t: dropped expected %0d got %0d", $time, want.dropped,
                           got.dropped);
                  error_count++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            rq_in.kind         = kind_type'(req_tdata[2:0]);
            rq_in.id           = req_tdata[18:3];
            rq_in.handle       = req_tdata[50:19];
            rq_in.new_capacity = req_tdata[55:51];
            expected_rsps.push_back(serve_request(rq_in));
         end
      end
   end
endmodule

@@ verif/testbench.sv @@
// Stimulus and verdict for the broadcast message queue.
module testbench;
   import bmq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT = 5000;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [55:0] req_tdata;   // kind, subscriber_id, message_handle, new_capacity
   logic rsp_tvalid;
   logic rsp_tready;
   logic [47:0] rsp_tdata;   // status, message_handle_out, available, dropped
   int error_count;
   int pending_count;
   bit calm;          // no idling in the last part
   bit hold_rsp;      // long receiver hold-off
   int quiet_cycles;

   broadcast_message_queue_top dut (.*);

   bmq_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles without any beat
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Verification failed");
            $finish;
         end
      end
   end

   // receiver: random stall bursts, or a long hold-off
   initial begin
      int gap;
      rsp_tready = 0;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_tready <= 0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 5);
            rsp_tready <= 0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_tready <= 1;
            @(negedge clock);
         end
      end
   end

   // offer one beat and wait until it has been taken; valid stays up afterwards
   task automatic send_op(kind_type k, logic [15:0] id, logic [31:0] h, logic [4:0] nc);
      int gap;
      if (!calm && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 5);
         req_tvalid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {nc, h, id, k};
      // ready is stable between edges, so the beat goes at the next rising edge
      while (!req_tready) @(negedge clock);
      @(negedge clock);
   endtask

   // ids drawn mostly from a small pool so operations hit registered subscribers
   function automatic logic [15:0] pick_id();
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'(($urandom));
         2: return 16'hFFFF;
         default: return 16'($urandom_range(1, 10));
      endcase
   endfunction

   function automatic logic [31:0] pick_handle();
      case ($urandom_range(0, 5))
         0: return 32'($urandom);
         1: return 32'hFFFF_FFFF;
         default: return 32'($urandom_range(0, 12));
      endcase
   endfunction

   function automatic kind_type pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 12) return KIND_SUBSCRIBE;
      if (r < 20) return KIND_UNSUBSCRIBE;
      if (r < 45) return KIND_ADD;
      if (r < 70) return KIND_GET;
      if (r < 80) return KIND_COUNT;
      if (r < 88) return KIND_REMOVE;
      if (r < 95) return KIND_RESIZE;
      return KIND_NONE;
   endfunction

   function automatic logic [4:0] pick_cap();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6) return 5'($urandom_range(8, 16));
      if (r < 8) return 5'($urandom_range(0, 7));
      return 5'($urandom_range(17, 31));
   endfunction

   initial begin
      calm = 0;
      hold_rsp = 0;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      repeat (11) @(negedge clock);
      reset = 0;

      // directed part
      send_op(KIND_SUBSCRIBE, 16'd0, 32'd0, 5'd0);
      send_op(KIND_GET, 16'd5, 32'd0, 5'd0);
      send_op(KIND_ADD, 16'd0, 32'hFFFF_FFFF, 5'd0);
      for (int i = 1; i <= 8; i++) send_op(KIND_SUBSCRIBE, 16'(i), 32'd0, 5'd0);
      send_op(KIND_SUBSCRIBE, 16'hFFFF, 32'd0, 5'd0);
      send_op(KIND_SUBSCRIBE, 16'd3, 32'd0, 5'd0);
      send_op(KIND_ADD, 16'd0, 32'h1234_5678, 5'd0);
      send_op(KIND_ADD, 16'd0, 32'h1234_5678, 5'd0);
      send_op(KIND_COUNT, 16'd2, 32'd0, 5'd0);
      send_op(KIND_COUNT, 16'hFFFF, 32'd0, 5'd0);
      send_op(KIND_GET, 16'd1, 32'd0, 5'd0);
      send_op(KIND_REMOVE, 16'd0, 32'd0, 5'd0);
      send_op(KIND_REMOVE, 16'd0, 32'h1234_5678, 5'd0);
      send_op(KIND_REMOVE, 16'd0, 32'hDEAD_BEEF, 5'd0);
      send_op(KIND_UNSUBSCRIBE, 16'd0, 32'd0, 5'd0);
      send_op(KIND_UNSUBSCRIBE, 16'd8, 32'd0, 5'd0);
      send_op(KIND_RESIZE, 16'd0, 32'd0, 5'd31);
      send_op(KIND_NONE, 16'hFFFF, 32'hFFFF_FFFF, 5'd31);
      send_op(KIND_RESIZE, 16'd0, 32'd0, 5'd0);
      send_op(KIND_GET, 16'd2, 32'd0, 5'd0);
      send_op(KIND_ADD, 16'd0, 32'd7, 5'd0);
      send_op(KIND_RESIZE, 16'd0, 32'd0, 5'd16);

      // long receiver hold-off while requests keep coming
      hold_rsp = 1;
      for (int i = 0; i < 30; i++)
         send_op(i % 2 ? KIND_GET : KIND_ADD, pick_id(), pick_handle(), 5'd0);

      // random part
      for (int i = 0; i < 2000; i++) begin
         if (i == 1000) begin
            // pause until everything has drained
            req_tvalid <= 0;
            @(negedge clock);
            while (pending_count != 0) @(negedge clock);
         end
         if (i == 1700) calm = 1;
         send_op(pick_kind(), pick_id(), pick_handle(), pick_cap());
      end

      req_tvalid <= 0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
